>>> rtl/dadc_pkg.sv
// ----------------------------------------------------------------------------
// Dual average change detector package
// Fixed constants, register indexes and reset values shared by the design.
// ----------------------------------------------------------------------------
package dadc_pkg;

    // Rates are unsigned Q0.16 held in 17 bits, so that 1.0 fits.
    localparam int RATE_WIDTH = 17;
    localparam int RATE_FRAC  = 16;
    localparam logic [RATE_WIDTH-1:0] RATE_ONE = 17'h1_0000;

    // The reset threshold is 1.0 in Q6.18 and needs 19 bits.
    localparam int THRESHOLD_RESET_WIDTH = 19;

    localparam logic [RATE_WIDTH-1:0]            SLOW_RATE_RESET = 17'd655;
    localparam logic [RATE_WIDTH-1:0]            FAST_RATE_RESET = 17'd6554;
    localparam logic [THRESHOLD_RESET_WIDTH-1:0] THRESHOLD_RESET = 19'd262144;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_SLOW_RATE     = 2'd0,
        REG_FAST_RATE     = 2'd1,
        REG_GAP_THRESHOLD = 2'd2,
        REG_HOLDOFF_STEPS = 2'd3
    } reg_index_t;

endpackage

>>> rtl/dadc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Dual average change detector configuration registers
// APB-style register file holding the rates, the threshold and the cooldown.
// ----------------------------------------------------------------------------
module dadc_cfg_regs #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int STEP_WIDTH   = 32,
    parameter int THR_WIDTH    = 24,
    parameter int DATA_WIDTH   = 32,
    parameter int ADDR_WIDTH   = 4,
    parameter int ADDR_LSB     = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ADDR_WIDTH-1:0]           paddr,
    input  logic [DATA_WIDTH-1:0]           pwdata,
    output logic [DATA_WIDTH-1:0]           prdata,
    output logic                            pready,
    output logic [dadc_pkg::RATE_WIDTH-1:0] slow_rate,
    output logic [dadc_pkg::RATE_WIDTH-1:0] fast_rate,
    output logic [THR_WIDTH-1:0]            gap_threshold,
    output logic [STEP_WIDTH-1:0]           holdoff_steps
);

    logic [dadc_pkg::RATE_WIDTH-1:0] slow_rate_reg;
    logic [dadc_pkg::RATE_WIDTH-1:0] slow_rate_next;
    logic [dadc_pkg::RATE_WIDTH-1:0] fast_rate_reg;
    logic [dadc_pkg::RATE_WIDTH-1:0] fast_rate_next;
    logic [THR_WIDTH-1:0]            threshold_reg;
    logic [THR_WIDTH-1:0]            threshold_next;
    logic [STEP_WIDTH-1:0]           cooldown_reg;
    logic [STEP_WIDTH-1:0]           cooldown_next;
    logic                            write_en;
    dadc_pkg::reg_index_t            reg_index;

    assign pready    = 1'b1;
    assign write_en  = psel && penable && pwrite;
    assign reg_index = dadc_pkg::reg_index_t'(paddr[ADDR_WIDTH-1:ADDR_LSB]);

    always_comb
    begin
        slow_rate_next = slow_rate_reg;
        fast_rate_next = fast_rate_reg;
        threshold_next = threshold_reg;
        cooldown_next  = cooldown_reg;
        if (write_en)
        begin
            case (reg_index)
                dadc_pkg::REG_SLOW_RATE:
                    slow_rate_next = pwdata[dadc_pkg::RATE_WIDTH-1:0];
                dadc_pkg::REG_FAST_RATE:
                    fast_rate_next = pwdata[dadc_pkg::RATE_WIDTH-1:0];
                dadc_pkg::REG_GAP_THRESHOLD:
                    threshold_next = THR_WIDTH'(pwdata[SAMPLE_WIDTH-1:0]);
                dadc_pkg::REG_HOLDOFF_STEPS:
                    cooldown_next = pwdata[STEP_WIDTH-1:0];
                default:
                    slow_rate_next = slow_rate_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_rate_reg <= dadc_pkg::SLOW_RATE_RESET;
            fast_rate_reg <= dadc_pkg::FAST_RATE_RESET;
            threshold_reg <= THR_WIDTH'(dadc_pkg::THRESHOLD_RESET);
            cooldown_reg  <= '0;
        end
        else
        begin
            slow_rate_reg <= slow_rate_next;
            fast_rate_reg <= fast_rate_next;
            threshold_reg <= threshold_next;
            cooldown_reg  <= cooldown_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            dadc_pkg::REG_SLOW_RATE:     prdata = DATA_WIDTH'(slow_rate_reg);
            dadc_pkg::REG_FAST_RATE:     prdata = DATA_WIDTH'(fast_rate_reg);
            dadc_pkg::REG_GAP_THRESHOLD: prdata = DATA_WIDTH'(threshold_reg);
            dadc_pkg::REG_HOLDOFF_STEPS: prdata = DATA_WIDTH'(cooldown_reg);
            default:                     prdata = '0;
        endcase
    end

    assign slow_rate     = slow_rate_reg;
    assign fast_rate     = fast_rate_reg;
    assign gap_threshold = threshold_reg;
    assign holdoff_steps = cooldown_reg;

endmodule

>>> rtl/dadc_blend.sv
// ----------------------------------------------------------------------------
// Dual average change detector blend unit
// One exponential average update: avg + rate * (x - avg), truncated once.
// ----------------------------------------------------------------------------
module dadc_blend #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic [SAMPLE_WIDTH-1:0]         avg,
    input  logic [SAMPLE_WIDTH-1:0]         x,
    input  logic [dadc_pkg::RATE_WIDTH-1:0] rate,
    output logic [SAMPLE_WIDTH-1:0]         result
);

    localparam int PROD_WIDTH = SAMPLE_WIDTH + dadc_pkg::RATE_WIDTH + 2;

    logic [dadc_pkg::RATE_WIDTH-1:0]      rate_clamped;
    logic signed [dadc_pkg::RATE_WIDTH:0] rate_s;
    logic signed [SAMPLE_WIDTH:0]         diff;
    logic signed [PROD_WIDTH-1:0]         product;
    logic signed [PROD_WIDTH-1:0]         base;
    logic signed [PROD_WIDTH-1:0]         sum;

    // A rate above one behaves as one.
    assign rate_clamped = rate[dadc_pkg::RATE_WIDTH-1] ? dadc_pkg::RATE_ONE : rate;
    assign rate_s       = $signed({1'b0, rate_clamped});
    assign diff         = $signed({1'b0, x}) - $signed({1'b0, avg});
    assign product      = rate_s * diff;

    // (1 - r) * avg + r * x is the same as avg * 1.0 + r * (x - avg); the sum
    // is never negative, so the shift truncates the way the exact form does.
    assign base   = $signed({3'b000, avg, {dadc_pkg::RATE_FRAC{1'b0}}});
    assign sum    = base + product;
    assign result = sum[SAMPLE_WIDTH+dadc_pkg::RATE_FRAC-1:dadc_pkg::RATE_FRAC];

endmodule

>>> rtl/dual_average_change_detector.sv
// ----------------------------------------------------------------------------
// Dual average change detector
// Slow and fast exponential averages of a surprise stream with change flag.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word sits in the input register, moves on to the
// result register, then on the output; the averages update in one pass.
// Throughput: one word per cycle while out_ready is high.
// Reset: rst_n clears the pipeline, the averages, the primed flag and the
// last change step, and loads the register reset values.
// ----------------------------------------------------------------------------
module dual_average_change_detector #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int STEP_WIDTH   = 32,
    // These follow from the two above.
    localparam int DATA_WIDTH  = (SAMPLE_WIDTH > 32 || STEP_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB    = (DATA_WIDTH == 64) ? 3 : 2,
    localparam int ADDR_WIDTH  = ADDR_LSB + 2
) (
    input  logic                    clk,
    input  logic                    rst_n,

    // Configuration port.
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_WIDTH-1:0]   paddr,
    input  logic [DATA_WIDTH-1:0]   pwdata,
    output logic [DATA_WIDTH-1:0]   prdata,
    output logic                    pready,

    // Input channel.
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    sample_valid,
    input  logic [SAMPLE_WIDTH-1:0] surprise_value,
    input  logic [STEP_WIDTH-1:0]   step,

    // Output channel.
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    change_flag,
    output logic [SAMPLE_WIDTH-1:0] slow_average,
    output logic [SAMPLE_WIDTH-1:0] fast_average
);

    // The threshold register keeps enough bits for its reset value of 1.0,
    // even when the sample format is narrower.
    localparam int THR_WIDTH = (SAMPLE_WIDTH > dadc_pkg::THRESHOLD_RESET_WIDTH) ?
                               SAMPLE_WIDTH : dadc_pkg::THRESHOLD_RESET_WIDTH;

    logic [dadc_pkg::RATE_WIDTH-1:0] slow_rate;
    logic [dadc_pkg::RATE_WIDTH-1:0] fast_rate;
    logic [THR_WIDTH-1:0]            gap_threshold;
    logic [STEP_WIDTH-1:0]           holdoff_steps;

    // Input register stage.
    logic                    in_valid_reg;
    logic                    in_sample_valid_reg;
    logic [SAMPLE_WIDTH-1:0] in_surprise_reg;
    logic [STEP_WIDTH-1:0]   in_step_reg;

    // Detector state.
    logic [SAMPLE_WIDTH-1:0] slow_value_reg;
    logic [SAMPLE_WIDTH-1:0] slow_value_next;
    logic [SAMPLE_WIDTH-1:0] fast_value_reg;
    logic [SAMPLE_WIDTH-1:0] fast_value_next;
    logic                    primed_reg;
    logic                    primed_next;
    logic [STEP_WIDTH-1:0]   last_change_reg;
    logic [STEP_WIDTH-1:0]   last_change_next;

    // Result register stage.
    logic                    out_valid_reg;
    logic                    out_change_reg;
    logic [SAMPLE_WIDTH-1:0] out_slow_reg;
    logic [SAMPLE_WIDTH-1:0] out_fast_reg;

    logic                    advance;
    logic                    accept;
    logic [SAMPLE_WIDTH-1:0] slow_blend;
    logic [SAMPLE_WIDTH-1:0] fast_blend;
    logic [SAMPLE_WIDTH:0]   avg_gap;
    logic [STEP_WIDTH:0]     cooldown_end;
    logic                    cooldown_passed;
    logic                    change_next;

    dadc_cfg_regs #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STEP_WIDTH   (STEP_WIDTH),
        .THR_WIDTH    (THR_WIDTH),
        .DATA_WIDTH   (DATA_WIDTH),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .ADDR_LSB     (ADDR_LSB)
    ) u_cfg_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .slow_rate     (slow_rate),
        .fast_rate     (fast_rate),
        .gap_threshold (gap_threshold),
        .holdoff_steps (holdoff_steps)
    );

    // The word in the input register moves on whenever the result register
    // is empty or is being emptied in the same cycle. The input register in
    // turn takes a new word whenever it is empty or moving on, so the stream
    // runs at one word per cycle while out_ready is high; a stalled result
    // register holds the input register full and so drops in_ready.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sample_valid_reg <= sample_valid;
            in_surprise_reg     <= surprise_value;
            in_step_reg         <= step;
        end
    end

    // Both averages update from the current state in one pass. The state is
    // written only as a word advances, so the next word always sees the
    // state left by the one before it.
    dadc_blend #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_slow_blend (
        .avg    (slow_value_reg),
        .x      (in_surprise_reg),
        .rate   (slow_rate),
        .result (slow_blend)
    );

    dadc_blend #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_fast_blend (
        .avg    (fast_value_reg),
        .x      (in_surprise_reg),
        .rate   (fast_rate),
        .result (fast_blend)
    );

    // The cooldown end is formed one bit wider than the step; a carry out
    // means the cooldown cannot have passed yet.
    assign cooldown_end    = {1'b0, last_change_reg} + {1'b0, holdoff_steps};
    assign cooldown_passed = !cooldown_end[STEP_WIDTH] &&
                             (in_step_reg >= cooldown_end[STEP_WIDTH-1:0]);

    // The gap is meaningful only when the fast average is above the slow one;
    // otherwise it wraps and the magnitude test is masked off.
    assign avg_gap = {1'b0, fast_blend} - {1'b0, slow_blend};

    always_comb
    begin
        slow_value_next  = slow_value_reg;
        fast_value_next  = fast_value_reg;
        primed_next      = primed_reg;
        last_change_next = last_change_reg;
        change_next      = 1'b0;
        if (in_sample_valid_reg)
        begin
            if (!primed_reg)
            begin
                // The first finite sample seeds both averages and never
                // reports a change.
                slow_value_next = in_surprise_reg;
                fast_value_next = in_surprise_reg;
                primed_next     = 1'b1;
            end
            else
            begin
                slow_value_next = slow_blend;
                fast_value_next = fast_blend;
                change_next     = cooldown_passed && (fast_blend > slow_blend) &&
                                  (THR_WIDTH'(avg_gap[SAMPLE_WIDTH-1:0]) > gap_threshold);
                if (change_next)
                begin
                    last_change_next = in_step_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_value_reg  <= '0;
            fast_value_reg  <= '0;
            primed_reg      <= 1'b0;
            last_change_reg <= '0;
        end
        else if (advance)
        begin
            slow_value_reg  <= slow_value_next;
            fast_value_reg  <= fast_value_next;
            primed_reg      <= primed_next;
            last_change_reg <= last_change_next;
        end
    end

    // Result register. An ignored sample still produces a word that reports
    // the held averages and no change.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_change_reg <= change_next;
            out_slow_reg   <= slow_value_next;
            out_fast_reg   <= fast_value_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign change_flag  = out_change_reg;
    assign slow_average = out_slow_reg;
    assign fast_average = out_fast_reg;

endmodule
